>>> design/astar_pkg.sv
// ----------------------------------------------------------------------------
// A* shortest path package
// Shared state codes, register indexes and score constants.
// ----------------------------------------------------------------------------
package astar_pkg;

   localparam int SCORE_W = 24;
   localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
   localparam int COST_W = 16;
   localparam int VCODE_W = 5;

   // configuration register indexes
   localparam logic REG_START = 1'b0;
   localparam logic REG_GOAL = 1'b1;

   typedef enum logic [4:0] {
      ST_LOAD,
      ST_CLEAR,
      ST_INIT,
      ST_SEL_RD,
      ST_SEL_CMP,
      ST_EXP_RD,
      ST_EXP_EDGE,
      ST_PAIR_RD,
      ST_PAIR_CHK,
      ST_NB_RD,
      ST_NB_UPD,
      ST_PATH_RD,
      ST_PATH_WR,
      ST_EMIT_RD,
      ST_EMIT,
      ST_FAIL
   } state_type;

endpackage

>>> design/astar_if.sv
// ----------------------------------------------------------------------------
// Stream channel interfaces
// Valid/ready channels for edges, path beats and register writes.
// ----------------------------------------------------------------------------
interface astar_req_if;
   logic       valid;
   logic       ready;
   logic [4:0] from_vertex;
   logic [4:0] to_vertex;
   logic [15:0] edge_cost;
   logic       last_edge;
   modport source (output valid, from_vertex, to_vertex, edge_cost, last_edge, input ready);
   modport sink (input valid, from_vertex, to_vertex, edge_cost, last_edge, output ready);
endinterface

interface astar_rsp_if;
   logic       valid;
   logic       ready;
   logic [4:0] path_vertex;
   logic       found;
   logic       last;
   modport source (output valid, path_vertex, found, last, input ready);
   modport sink (input valid, path_vertex, found, last, output ready);
endinterface

interface astar_csr_if;
   logic       valid;
   logic       ready;
   logic       index;
   logic [4:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> design/astar_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module astar_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

>>> design/astar_shortest_path.sv
// ----------------------------------------------------------------------------
// A* shortest path search
// Stores edges, then searches start to goal and streams the path.
// ----------------------------------------------------------------------------
// Edge beats: one per cycle while loading.
// Search on the last edge: each expansion scans all NUM_VERTICES open-set entries and
//   the stored edges, and each neighbour takes a pair lookup over the stored edges;
//   the path walk and the path output each step through the path vertex by vertex.
// After each run a clearing pass writes all NUM_VERTICES vertex entries, one a cycle.
// Reset: synchronous; control registers to 0, a clearing pass runs before edges are taken.
module astar_shortest_path #(
   parameter int NUM_VERTICES = 32,
   parameter int MAX_EDGES = 64
) (
   input  logic clock,
   input  logic reset,
   astar_req_if.sink   req,
   astar_rsp_if.source rsp,
   astar_csr_if.sink   csr
);
   localparam int VW = $clog2(NUM_VERTICES);
   localparam int EW = $clog2(MAX_EDGES);
   localparam int CW = $clog2(MAX_EDGES + 1);
   localparam int VCW = $clog2(NUM_VERTICES + 1);
   localparam int OW = VCW + 1;
   localparam int SW = astar_pkg::SCORE_W;
   // vertex entry: g, f, pred valid, pred, open, closed, order
   localparam int NW = 2 * SW + 1 + VW + 2 + OW;

   astar_pkg::state_type state_ff, state_in;

   logic [4:0] start_ff, goal_ff;
   logic [CW-1:0] ecnt_ff, ecnt_in;
   logic [EW-1:0] eidx_ff, eidx_in, kidx_ff, kidx_in;
   logic [VCW-1:0] vidx_ff, vidx_in;
   logic [VW-1:0] cur_ff, cur_in, best_ff, best_in, nb_ff, nb_in;
   logic best_ok_ff, best_ok_in;
   logic [SW-1:0] bestf_ff, bestf_in, curg_ff, curg_in, tent_ff, tent_in;
   logic [OW-1:0] besto_ff, besto_in, ins_ff, ins_in;
   logic sseen_ff, sseen_in, gseen_ff, gseen_in;
   logic [VCW-1:0] plen_ff, plen_in;
   logic rvalid_ff, rvalid_in;
   logic [4:0] rvert_ff, rvert_in;
   logic rfound_ff, rfound_in, rlast_ff, rlast_in;

   // memories
   logic          e_we;
   logic [EW-1:0] e_wa, e_ra;
   logic [25:0]   e_wd, e_rd;
   logic          v_we;
   logic [VW-1:0] v_wa, v_ra;
   logic [NW-1:0] v_wd, v_rd;
   logic          p_we;
   logic [VW-1:0] p_wa, p_ra;
   logic [VW-1:0] p_wd, p_rd;

   astar_ram #(.WIDTH(26), .DEPTH(MAX_EDGES)) u_edge (
      .clock, .wr_en(e_we), .wr_addr(e_wa), .wr_data(e_wd), .rd_addr(e_ra), .rd_data(e_rd));
   astar_ram #(.WIDTH(NW), .DEPTH(NUM_VERTICES)) u_vert (
      .clock, .wr_en(v_we), .wr_addr(v_wa), .wr_data(v_wd), .rd_addr(v_ra), .rd_data(v_rd));
   astar_ram #(.WIDTH(VW), .DEPTH(NUM_VERTICES)) u_path (
      .clock, .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd), .rd_addr(p_ra), .rd_data(p_rd));

   // unpack reads
   logic [4:0]  er_src, er_dst;
   logic [15:0] er_cost;
   assign er_src = e_rd[25:21];
   assign er_dst = e_rd[20:16];
   assign er_cost = e_rd[15:0];

   logic [SW-1:0] vr_g, vr_f;
   logic          vr_pv, vr_open, vr_closed;
   logic [VW-1:0] vr_pred;
   logic [OW-1:0] vr_ord;
   assign {vr_g, vr_f, vr_pv, vr_pred, vr_open, vr_closed, vr_ord} = v_rd;

   function automatic logic [NW-1:0] pack_v(logic [SW-1:0] g, logic [SW-1:0] f, logic pv,
                                           logic [VW-1:0] pr, logic op, logic cl,
                                           logic [OW-1:0] od);
      pack_v = {g, f, pv, pr, op, cl, od};
   endfunction

   function automatic logic [SW-1:0] sat_add(logic [SW-1:0] a, logic [SW-1:0] b);
      logic [SW:0] s;
      s = {1'b0, a} + {1'b0, b};
      sat_add = s[SW] ? astar_pkg::SCORE_MAX : s[SW-1:0];
   endfunction

   function automatic logic [SW-1:0] heur(logic [VW-1:0] v, logic [4:0] gl);
      logic [VW:0] d, a, b;
      a = {1'b0, v};
      b = VW + 1 >= 5 ? (VW + 1)'(gl) : (VW + 1)'(gl);
      d = (a > b) ? a - b : b - a;
      heur = SW'({d, 8'h00});
   endfunction

   logic in_hs, out_hs, st_fit;
   assign in_hs = req.valid && req.ready;
   assign out_hs = rsp.valid && rsp.ready;
   assign st_fit = (ecnt_ff < CW'(MAX_EDGES)) && (32'(req.from_vertex) < NUM_VERTICES) &&
                   (32'(req.to_vertex) < NUM_VERTICES);

   logic goal_ok, start_ok;
   assign goal_ok = 32'(goal_ff) < NUM_VERTICES;
   assign start_ok = 32'(start_ff) < NUM_VERTICES;
   logic [VW-1:0] goal_v, start_v;
   assign goal_v = VW'(goal_ff);
   assign start_v = VW'(start_ff);

   assign req.ready = (state_ff == astar_pkg::ST_LOAD);
   assign csr.ready = 1'b1;
   assign rsp.valid = rvalid_ff;
   assign rsp.path_vertex = rvert_ff;
   assign rsp.found = rfound_ff;
   assign rsp.last = rlast_ff;

   // next state and datapath
   always_comb begin
      state_in = state_ff;
      ecnt_in = ecnt_ff; eidx_in = eidx_ff; kidx_in = kidx_ff; vidx_in = vidx_ff;
      cur_in = cur_ff; best_in = best_ff; best_ok_in = best_ok_ff; nb_in = nb_ff;
      bestf_in = bestf_ff; besto_in = besto_ff; curg_in = curg_ff; tent_in = tent_ff;
      ins_in = ins_ff; sseen_in = sseen_ff; gseen_in = gseen_ff; plen_in = plen_ff;
      rvalid_in = rvalid_ff && !out_hs;
      rvert_in = rvert_ff; rfound_in = rfound_ff; rlast_in = rlast_ff;
      e_we = 1'b0; e_wa = EW'(ecnt_ff); e_wd = {req.from_vertex, req.to_vertex, req.edge_cost};
      e_ra = eidx_ff;
      v_we = 1'b0; v_wa = VW'(vidx_ff); v_wd = v_rd; v_ra = VW'(vidx_ff);
      p_we = 1'b0; p_wa = VW'(plen_ff); p_wd = '0; p_ra = VW'(plen_ff);

      unique case (state_ff)
         astar_pkg::ST_LOAD: begin
            if (in_hs) begin
               if (st_fit) begin
                  e_we = 1'b1;
                  ecnt_in = ecnt_ff + 1'b1;
                  if (req.from_vertex == start_ff) sseen_in = 1'b1;
                  if (req.to_vertex == goal_ff) gseen_in = 1'b1;
               end
               if (req.last_edge) state_in = astar_pkg::ST_INIT;
            end
         end
         astar_pkg::ST_INIT: begin
            if (!sseen_ff || !gseen_ff || !start_ok || !goal_ok) begin
               state_in = astar_pkg::ST_FAIL;
            end else begin
               v_we = 1'b1; v_wa = start_v;
               v_wd = pack_v('0, heur(start_v, goal_ff), 1'b0, '0, 1'b1, 1'b0, '0);
               ins_in = OW'(1);
               vidx_in = '0;
               best_ok_in = 1'b0;
               state_in = astar_pkg::ST_SEL_RD;
            end
         end
         astar_pkg::ST_SEL_RD: begin
            v_ra = VW'(vidx_ff);
            state_in = astar_pkg::ST_SEL_CMP;
         end
         astar_pkg::ST_SEL_CMP: begin
            if (vr_open && (!best_ok_ff || vr_f < bestf_ff ||
                (vr_f == bestf_ff && vr_ord < besto_ff))) begin
               best_ok_in = 1'b1; best_in = VW'(vidx_ff);
               bestf_in = vr_f; besto_in = vr_ord;
            end
            if (32'(vidx_ff) == NUM_VERTICES - 1) begin
               vidx_in = '0;
               state_in = astar_pkg::ST_EXP_RD;
            end else begin
               vidx_in = vidx_ff + 1'b1;
               state_in = astar_pkg::ST_SEL_RD;
            end
         end
         astar_pkg::ST_EXP_RD: begin
            // pick made: fail, finish, or close it
            if (!best_ok_ff) begin
               state_in = astar_pkg::ST_FAIL;
            end else if (best_ff == goal_v) begin
               plen_in = '0; cur_in = goal_v;
               v_ra = goal_v;
               state_in = astar_pkg::ST_PATH_RD;
            end else begin
               v_ra = best_ff;
               cur_in = best_ff;
               state_in = astar_pkg::ST_PATH_WR;
               eidx_in = '0;
            end
         end
         astar_pkg::ST_PATH_WR: begin
            if (cur_ff == goal_v || !best_ok_ff) begin
               // path walk: record vertex, follow predecessor
               p_we = 1'b1; p_wa = VW'(plen_ff); p_wd = cur_ff;
               plen_in = plen_ff + 1'b1;
               if (!vr_pv || 32'(plen_ff) + 1 >= NUM_VERTICES) begin
                  state_in = astar_pkg::ST_EMIT_RD;
               end else begin
                  cur_in = vr_pred;
                  state_in = astar_pkg::ST_PATH_RD;
               end
            end else begin
               // close current
               curg_in = vr_g;
               v_we = 1'b1; v_wa = cur_ff;
               v_wd = pack_v(vr_g, vr_f, vr_pv, vr_pred, 1'b0, 1'b1, vr_ord);
               eidx_in = '0;
               e_ra = '0;
               state_in = (ecnt_ff == '0) ? astar_pkg::ST_SEL_RD : astar_pkg::ST_EXP_EDGE;
               if (ecnt_ff == '0) begin vidx_in = '0; best_ok_in = 1'b0; end
            end
         end
         astar_pkg::ST_PATH_RD: begin
            v_ra = cur_ff;
            best_ok_in = 1'b0;
            state_in = astar_pkg::ST_PATH_WR;
         end
         astar_pkg::ST_EXP_EDGE: begin
            // e_rd holds edge eidx
            if (er_src == 5'(cur_ff)) begin
               nb_in = VW'(er_dst);
               kidx_in = '0;
               e_ra = '0;
               state_in = astar_pkg::ST_PAIR_CHK;
            end else if (CW'(eidx_ff) + 1'b1 >= ecnt_ff) begin
               vidx_in = '0; best_ok_in = 1'b0;
               state_in = astar_pkg::ST_SEL_RD;
            end else begin
               eidx_in = eidx_ff + 1'b1;
               e_ra = eidx_ff + 1'b1;
               state_in = astar_pkg::ST_PAIR_RD;
            end
         end
         astar_pkg::ST_PAIR_RD: begin
            // wait for registered edge data
            e_ra = eidx_ff;
            state_in = astar_pkg::ST_EXP_EDGE;
         end
         astar_pkg::ST_PAIR_CHK: begin
            // first edge of (cur, nb) sets the cost; kidx is in flight
            e_ra = kidx_ff;
            if (kidx_in == kidx_ff && vidx_ff == '0) begin
               vidx_in = VCW'(1);
            end else if (er_src == 5'(cur_ff) && er_dst == 5'(nb_ff)) begin
               tent_in = sat_add(curg_ff, SW'(er_cost));
               v_ra = nb_ff;
               vidx_in = '0;
               state_in = astar_pkg::ST_NB_RD;
            end else begin
               kidx_in = kidx_ff + 1'b1;
               e_ra = kidx_ff + 1'b1;
               vidx_in = '0;
            end
         end
         astar_pkg::ST_NB_RD: begin
            v_ra = nb_ff;
            state_in = astar_pkg::ST_NB_UPD;
         end
         astar_pkg::ST_NB_UPD: begin
            if (!vr_closed) begin
               if (!vr_open) begin
                  v_we = 1'b1; v_wa = nb_ff;
                  v_wd = pack_v(tent_ff, sat_add(tent_ff, heur(nb_ff, goal_ff)), 1'b1,
                                cur_ff, 1'b1, 1'b0, ins_ff);
                  ins_in = ins_ff + 1'b1;
               end else if (tent_ff < vr_g) begin
                  v_we = 1'b1; v_wa = nb_ff;
                  v_wd = pack_v(tent_ff, sat_add(tent_ff, heur(nb_ff, goal_ff)), 1'b1,
                                cur_ff, 1'b1, 1'b0, vr_ord);
               end
            end
            if (CW'(eidx_ff) + 1'b1 >= ecnt_ff) begin
               vidx_in = '0; best_ok_in = 1'b0;
               state_in = astar_pkg::ST_SEL_RD;
            end else begin
               eidx_in = eidx_ff + 1'b1;
               state_in = astar_pkg::ST_PAIR_RD;
            end
         end
         astar_pkg::ST_EMIT_RD: begin
            p_ra = VW'(plen_ff - 1'b1);
            if (!rvalid_ff || out_hs) state_in = astar_pkg::ST_EMIT;
         end
         astar_pkg::ST_EMIT: begin
            rvalid_in = 1'b1;
            rvert_in = 5'(p_rd); rfound_in = 1'b1;
            rlast_in = (plen_ff == VCW'(1));
            plen_in = plen_ff - 1'b1;
            if (plen_ff == VCW'(1)) begin
               vidx_in = '0;
               state_in = astar_pkg::ST_CLEAR;
            end else begin
               state_in = astar_pkg::ST_EMIT_RD;
            end
         end
         astar_pkg::ST_FAIL: begin
            if (!rvalid_ff || out_hs) begin
               rvalid_in = 1'b1; rvert_in = '0; rfound_in = 1'b0; rlast_in = 1'b1;
               vidx_in = '0;
               state_in = astar_pkg::ST_CLEAR;
            end
         end
         astar_pkg::ST_CLEAR: begin
            v_we = 1'b1; v_wa = VW'(vidx_ff);
            v_wd = pack_v(astar_pkg::SCORE_MAX, astar_pkg::SCORE_MAX, 1'b0, '0, 1'b0, 1'b0, '0);
            ecnt_in = '0; sseen_in = 1'b0; gseen_in = 1'b0; ins_in = '0;
            vidx_in = vidx_ff + 1'b1;
            if (32'(vidx_ff) == NUM_VERTICES - 1) state_in = astar_pkg::ST_LOAD;
         end
         default: state_in = astar_pkg::ST_CLEAR;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= astar_pkg::ST_CLEAR;
         start_ff <= '0; goal_ff <= '0;
         ecnt_ff <= '0; vidx_ff <= '0; ins_ff <= '0;
         sseen_ff <= 1'b0; gseen_ff <= 1'b0; rvalid_ff <= 1'b0;
         best_ok_ff <= 1'b0; plen_ff <= '0; eidx_ff <= '0; kidx_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr.valid && csr.ready) begin
            if (csr.index == astar_pkg::REG_START) start_ff <= csr.data;
            else goal_ff <= csr.data;
         end
         ecnt_ff <= ecnt_in; vidx_ff <= vidx_in; ins_ff <= ins_in;
         sseen_ff <= sseen_in; gseen_ff <= gseen_in; rvalid_ff <= rvalid_in;
         best_ok_ff <= best_ok_in; plen_ff <= plen_in; eidx_ff <= eidx_in; kidx_ff <= kidx_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff <= cur_in; best_ff <= best_in; nb_ff <= nb_in;
      bestf_ff <= bestf_in; besto_ff <= besto_in; curg_ff <= curg_in; tent_ff <= tent_in;
      rvert_ff <= rvert_in; rfound_ff <= rfound_in; rlast_ff <= rlast_in;
   end

   // checks
   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !rvalid_ff || rlast_ff) else $error("edge taken during output");
   a_ecnt_cap: assert property (@(posedge clock) disable iff (reset)
      ecnt_ff <= CW'(MAX_EDGES)) else $error("edge count overflow");
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == astar_pkg::ST_CLEAR) |=> ecnt_ff == '0) else $error("clear kept edges");
endmodule

>>> dv/tb_astar_shortest_path.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// A* shortest path testbench
// Streams directed and random edge sets, predicts each search path in a
// behavioral copy of the block and checks every path beat as it leaves.
// ----------------------------------------------------------------------------
module tb_astar_shortest_path;

   localparam int NV = 32;
   localparam int NE = 64;
   localparam int VW = astar_pkg::VCODE_W;
   localparam int SW = astar_pkg::SCORE_W;
   localparam int DRAIN_CYCLES = 100;
   localparam int WATCHDOG_LIMIT = 400000;

   typedef struct packed {
      logic [VW-1:0] vertex;
      logic          found;
      logic          last;
   } path_beat_type;

   logic clock;
   logic reset;
   astar_req_if req ();
   astar_rsp_if rsp ();
   astar_csr_if csr ();

   astar_shortest_path u_dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source),
      .csr(csr.sink)
   );

   // predictor state
   logic [VW-1:0]                 cfg_start, cfg_goal;
   logic [VW-1:0]                 edge_src [NE];
   logic [VW-1:0]                 edge_dst [NE];
   logic [astar_pkg::COST_W-1:0]  edge_w [NE];
   int                            edge_num;
   bit                            start_hit, goal_hit;
   path_beat_type                 path_q [$];
   int                            errors;
   bit                            no_idle;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report(input string msg);
      $display("ERROR %0t: %s", $time, msg);
      errors++;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // append one expected path beat
   function automatic void queue_beat(input logic [VW-1:0] v, input logic fnd,
                                      input logic lst);
      path_beat_type beat;
      beat.vertex = v;
      beat.found = fnd;
      beat.last = lst;
      path_q.insert(path_q.size(), beat);
   endfunction

   function automatic logic [SW-1:0] add_sat(input logic [SW-1:0] a,
                                            input logic [SW-1:0] b);
      logic [SW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SW] ? astar_pkg::SCORE_MAX : s[SW-1:0];
   endfunction

   function automatic logic [SW-1:0] dist_to_goal(input int v);
      int d;
      d = (v > cfg_goal) ? v - cfg_goal : cfg_goal - v;
      return SW'(d * 256);
   endfunction

   function automatic logic [SW-1:0] first_pair_cost(input int a, input int b);
      for (int k = 0; k < edge_num; k++)
         if (edge_src[k] == a && edge_dst[k] == b) return SW'(edge_w[k]);
      return astar_pkg::SCORE_MAX;
   endfunction

   // Run the search on the held edges and queue the expected path beats.
   function automatic void search_path();
      logic [SW-1:0] g [NV];
      logic [SW-1:0] f [NV];
      int pred [NV];
      bit open [NV];
      bit closed [NV];
      int order [NV];
      int trail [$];
      int ins, cur, nb, w;
      logic [SW-1:0] tent;
      if (!start_hit || !goal_hit) begin
         queue_beat('0, 1'b0, 1'b1);
         return;
      end
      for (int v = 0; v < NV; v++) begin
         g[v] = astar_pkg::SCORE_MAX; f[v] = astar_pkg::SCORE_MAX; pred[v] = -1;
         open[v] = 0; closed[v] = 0; order[v] = 0;
      end
      ins = 0;
      g[cfg_start] = '0;
      f[cfg_start] = dist_to_goal(cfg_start);
      open[cfg_start] = 1;
      order[cfg_start] = ins++;
      forever begin
         cur = -1;
         for (int v = 0; v < NV; v++) begin
            if (!open[v]) continue;
            if (cur < 0 || f[v] < f[cur] || (f[v] == f[cur] && order[v] < order[cur]))
               cur = v;
         end
         if (cur < 0) begin
            queue_beat('0, 1'b0, 1'b1);
            return;
         end
         if (cur == cfg_goal) begin
            w = cur;
            while (trail.size() < NV) begin
               trail.push_front(w);
               if (pred[w] < 0) break;
               w = pred[w];
            end
            foreach (trail[k])
               queue_beat(VW'(trail[k]), 1'b1, k == trail.size() - 1);
            return;
         end
         open[cur] = 0;
         closed[cur] = 1;
         for (int e = 0; e < edge_num; e++) begin
            if (edge_src[e] != cur) continue;
            nb = edge_dst[e];
            if (closed[nb]) continue;
            tent = add_sat(g[cur], first_pair_cost(cur, nb));
            if (open[nb]) begin
               if (tent >= g[nb]) continue;
            end else begin
               open[nb] = 1;
               order[nb] = ins++;
            end
            pred[nb] = cur;
            g[nb] = tent;
            f[nb] = add_sat(tent, dist_to_goal(nb));
         end
      end
   endfunction

   function automatic void take_edge(input logic [4:0] a, input logic [4:0] b,
                                     input logic [15:0] c, input logic fin);
      if (edge_num < NE) begin
         edge_src[edge_num] = a;
         edge_dst[edge_num] = b;
         edge_w[edge_num] = c;
         edge_num++;
         if (a == cfg_start) start_hit = 1;
         if (b == cfg_goal) goal_hit = 1;
      end
      if (fin) begin
         search_path();
         edge_num = 0;
         start_hit = 0;
         goal_hit = 0;
      end
   endfunction

   // Send one edge beat and fold it into the prediction on acceptance.
   task automatic send_edge(input logic [4:0] a, input logic [4:0] b,
                            input logic [15:0] c, input logic fin);
      int n;
      n = pick_gap();
      repeat (n) begin
         @(negedge clock);
         req.valid <= 1'b0;
      end
      @(negedge clock);
      req.valid <= 1'b1;
      req.from_vertex <= a;
      req.to_vertex <= b;
      req.edge_cost <= c;
      req.last_edge <= fin;
      do @(posedge clock); while (!req.ready);
      take_edge(a, b, c, fin);
   endtask

   // Hold off until the path drains and the clearing pass is over.
   task automatic wait_drained();
      @(negedge clock);
      req.valid <= 1'b0;
      while (path_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [4:0] val);
      wait_drained();
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= val;
      do @(posedge clock); while (!csr.ready);
      if (idx == astar_pkg::REG_START) cfg_start = val;
      else cfg_goal = val;
      @(negedge clock);
      csr.valid <= 1'b0;
   endtask

   task automatic set_ends(input logic [4:0] s, input logic [4:0] g);
      write_reg(astar_pkg::REG_START, s);
      write_reg(astar_pkg::REG_GOAL, g);
   endtask

   // result sink: random stalls of random length, none while no_idle is set
   initial begin : rsp_stall
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp.ready <= 1'b0;
            hold--;
         end else begin
            rsp.ready <= 1'b1;
            hold = pick_gap();
         end
      end
   end

   // compare each accepted path beat with the oldest expectation
   always @(posedge clock) begin
      path_beat_type exp_beat;
      if (!reset && rsp.valid && rsp.ready) begin
         if (path_q.size() == 0) begin
            report($sformatf("unexpected beat vertex=%0d found=%0b last=%0b",
                             rsp.path_vertex, rsp.found, rsp.last));
         end else begin
            exp_beat = path_q.pop_front();
            if (rsp.path_vertex !== exp_beat.vertex)
               report($sformatf("path_vertex %0d, expected %0d",
                                rsp.path_vertex, exp_beat.vertex));
            if (rsp.found !== exp_beat.found)
               report($sformatf("found %0b, expected %0b", rsp.found, exp_beat.found));
            if (rsp.last !== exp_beat.last)
               report($sformatf("last %0b, expected %0b", rsp.last, exp_beat.last));
         end
      end
   end

   // end the run when no channel moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
             (csr.valid && csr.ready) || reset)
            quiet = 0;
         else
            quiet++;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("tb_astar_shortest_path: FAIL");
            $finish;
         end
      end
   end

   // special cases on small hand-made graphs
   task automatic test_directed();
      // start equals goal at the reset registers
      send_edge(5'd0, 5'd0, 16'd5, 1'b1);
      set_ends(5'd1, 5'd4);
      // chain with a costly shortcut; the repeated pair keeps its first cost
      send_edge(5'd1, 5'd2, 16'h0100, 1'b0);
      send_edge(5'd1, 5'd2, 16'h0001, 1'b0);
      send_edge(5'd2, 5'd3, 16'h0080, 1'b0);
      send_edge(5'd1, 5'd4, 16'hFFFF, 1'b0);
      send_edge(5'd3, 5'd4, 16'h0000, 1'b1);
      // start never a source
      send_edge(5'd2, 5'd4, 16'd1, 1'b1);
      // goal never a target
      send_edge(5'd1, 5'd3, 16'd1, 1'b1);
      // goal unreachable
      send_edge(5'd1, 5'd2, 16'd1, 1'b0);
      send_edge(5'd3, 5'd4, 16'd1, 1'b1);
      // two routes to the goal: the lower f score at vertex 3 wins over the cheaper route via 2
      send_edge(5'd1, 5'd3, 16'h0100, 1'b0);
      send_edge(5'd1, 5'd2, 16'h0100, 1'b0);
      send_edge(5'd3, 5'd4, 16'h0100, 1'b0);
      send_edge(5'd2, 5'd4, 16'h0000, 1'b1);
      // extreme register values and costs
      set_ends(5'd31, 5'd0);
      send_edge(5'd0, 5'd31, 16'h0000, 1'b0);
      send_edge(5'd31, 5'd0, 16'hFFFF, 1'b1);
      set_ends(5'd0, 5'd31);
      send_edge(5'd0, 5'd31, 16'hFFFF, 1'b1);
   endtask

   // overfill the edge store; the dropped last edge still starts the search
   task automatic test_store_full();
      set_ends(5'd3, 5'd9);
      for (int k = 0; k < NE + 4; k++)
         send_edge(5'($urandom_range(0, 11)), 5'($urandom_range(0, 11)),
                   16'($urandom), k == NE + 3);
   endtask

   // random graphs, mostly dense around the current endpoints
   task automatic test_random(input int budget);
      int sent, len, base, span, runs;
      logic [4:0] a, b;
      sent = 0;
      runs = 0;
      while (sent < budget) begin
         if (runs % 4 == 3) begin
            a = 5'($urandom);
            b = ($urandom_range(0, 4) == 0) ? a : 5'($urandom);
            set_ends(a, b);
         end
         if (runs == 6) wait_drained();
         no_idle = (runs % 5 == 2);
         len = $urandom_range(1, 10);
         span = $urandom_range(2, 8);
         base = $urandom_range(0, 31);
         for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) < 8) begin
               a = (k == 0) ? cfg_start : 5'(base + $urandom_range(0, span));
               b = (k == len - 1) ? cfg_goal : 5'(base + $urandom_range(0, span));
               if ($urandom_range(0, 3) == 0) a = cfg_start;
               if ($urandom_range(0, 3) == 0) b = cfg_goal;
            end else begin
               a = 5'($urandom);
               b = 5'($urandom);
            end
            send_edge(a, b, ($urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 767))),
                      k == len - 1);
         end
         sent += len;
         runs++;
      end
      no_idle = 0;
   endtask

   initial begin
      errors = 0;
      no_idle = 0;
      cfg_start = '0;
      cfg_goal = '0;
      edge_num = 0;
      start_hit = 0;
      goal_hit = 0;
      reset = 1'b1;
      req.valid = 1'b0;
      req.from_vertex = '0;
      req.to_vertex = '0;
      req.edge_cost = '0;
      req.last_edge = 1'b0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0;
      csr.index = astar_pkg::REG_START;
      csr.data = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_store_full();
      test_random(45);
      wait_drained();
      if (errors == 0)
         $display("tb_astar_shortest_path: PASS");
      else
         $display("tb_astar_shortest_path: FAIL");
      $finish;
   end

endmodule
